// File: sv/bah_pkg.sv
`default_nettype none
package bah_pkg;

  localparam int XW        = 32;
  localparam int SUM_W     = 48;
  localparam int CNT_W     = 24;
  localparam int BIN_OUT_W = 6;
  localparam int DIV_CNT_W = $clog2(SUM_W);
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;

  typedef logic [SUM_W-1:0] sum_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    sum_t sum;
    cnt_t count;
  } entry_t;

  localparam sum_t SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam cnt_t CNT_MAX = {CNT_W{1'b1}};

  localparam logic [XW-1:0] AVG_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [XW-1:0] AVG_NEG_MAG = 32'h8000_0000;

  // opcodes
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // result status codes
  localparam logic [1:0] ST_ADDED   = 2'd0;
  localparam logic [1:0] ST_DROPPED = 2'd1;
  localparam logic [1:0] ST_READ    = 2'd2;

  // register indexes (word address)
  localparam logic [1:0] REG_X_MIN   = 2'd0;
  localparam logic [1:0] REG_X_MAX   = 2'd1;
  localparam logic [1:0] REG_INV_BIN = 2'd2;

  localparam logic [XW-1:0] X_MIN_RST   = 32'd0;
  localparam logic [XW-1:0] X_MAX_RST   = 32'd4194304;
  localparam logic [XW-1:0] INV_BIN_RST = 32'd65536;

endpackage
`default_nettype wire

// File: sv/bah_ifs.sv
`default_nettype none
interface bah_sample_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic signed [31:0] x_value;
  logic signed [31:0] y_value;
  logic [5:0]         read_bin;

  modport source(output valid, opcode, x_value, y_value, read_bin, input ready);
  modport sink(input valid, opcode, x_value, y_value, read_bin, output ready);
endinterface

interface bah_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [5:0]         bin_index;
  logic signed [31:0] average;
  logic [23:0]        entry_count;

  modport source(output valid, status, bin_index, average, entry_count, input ready);
  modport sink(input valid, status, bin_index, average, entry_count, output ready);
endinterface
`default_nettype wire

// File: sv/binned_average_histogram_top.sv
// add: request accept, then subtract, multiply, bin read, bin write, result to the output
//   register; a dropped sample goes from the range check to the result, a read goes straight
//   to the bin read, then through the 48-step divider only for a filled in-range bin
// one request at a time; a held result stalls the next one in its last stage until the
//   output register frees up
// reset: loads register defaults, then zeroes the bins in a clearing pass, no accept
`default_nettype none
module binned_average_histogram_top #(
  parameter int NUM_BINS = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  bah_sample_if.sink                        sample,
  bah_result_if.source                      result,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [bah_pkg::APB_AW-1:0]   paddr,
  input  wire logic [bah_pkg::APB_DW-1:0]   pwdata,
  output logic      [bah_pkg::APB_DW-1:0]   prdata,
  output logic                              pready
);

  localparam int BIN_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int WIDE  = 13;  // holds any bin number below 8192

  // sequencer codes
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIFF  = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_UPD   = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  // configuration registers
  logic [31:0] x_min;
  logic [31:0] x_max;
  logic [31:0] inv_bin_width;

  logic             cfg_wr;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_min         <= bah_pkg::X_MIN_RST;
      x_max         <= bah_pkg::X_MAX_RST;
      inv_bin_width <= bah_pkg::INV_BIN_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        bah_pkg::REG_X_MIN:   x_min         <= pwdata;
        bah_pkg::REG_X_MAX:   x_max         <= pwdata;
        bah_pkg::REG_INV_BIN: inv_bin_width <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      bah_pkg::REG_X_MIN:   prdata = x_min;
      bah_pkg::REG_X_MAX:   prdata = x_max;
      bah_pkg::REG_INV_BIN: prdata = inv_bin_width;
      default:              prdata = '0;
    endcase
  end

  // sequencer and request capture
  logic [2:0]        state;
  logic [BIN_W-1:0]  clr_idx;
  logic              op_q;
  logic [31:0]       x_q;
  logic [31:0]       y_q;
  logic [5:0]        rb_q;
  logic [31:0]       diff_q;
  logic [31:0]       prod_hi;
  logic [BIN_W-1:0]  bin_q;
  logic              oor_q;
  logic              neg_q;

  // staged result, then the output register
  logic [1:0]        res_status;
  logic [5:0]        res_bin;
  logic [31:0]       res_avg;
  bah_pkg::cnt_t     res_count;
  logic              out_valid;
  logic              out_load;
  logic [1:0]        out_status;
  logic [5:0]        out_bin;
  logic [31:0]       out_avg;
  bah_pkg::cnt_t     out_count;

  // datapath
  logic [32:0]       diff_full;
  logic              x_drop;
  logic [63:0]       prod;
  logic [WIDE-1:0]   rb_wide;
  logic [WIDE-1:0]   bin_wide;
  logic              rd_oor;
  logic [BIN_W-1:0]  bin_clamp;
  logic [BIN_W-1:0]  bin_sel;
  bah_pkg::entry_t   rd_entry;
  logic [bah_pkg::SUM_W:0] sum_ext;
  bah_pkg::sum_t     sum_new;
  bah_pkg::cnt_t     cnt_new;
  bah_pkg::sum_t     mag;
  bah_pkg::sum_t     quo;
  logic [31:0]       quo_sat;
  logic [31:0]       avg_val;
  logic              div_start;
  logic              div_done;

  // memory port signals
  logic                         ram_we;
  logic [BIN_W-1:0]             ram_waddr;
  logic [$bits(bah_pkg::entry_t)-1:0] ram_wdata;
  logic [$bits(bah_pkg::entry_t)-1:0] ram_rdata;

  always_comb begin
    // range check and offset from the lower edge
    diff_full = {x_q[31], x_q} - {x_min[31], x_min};
    x_drop    = ($signed(x_q) > $signed(x_max)) || ($signed(x_q) < $signed(x_min));
    // offset times reciprocal width, integer part picks the bin
    prod      = 64'(diff_q) * 64'(inv_bin_width);
    bin_clamp = (prod_hi >= 32'(NUM_BINS)) ? BIN_W'(NUM_BINS - 1) : prod_hi[BIN_W-1:0];
    rb_wide   = WIDE'(rb_q);
    rd_oor    = rb_wide >= WIDE'(NUM_BINS);
    bin_sel   = (op_q == bah_pkg::OP_READ) ? rb_wide[BIN_W-1:0] : bin_clamp;
    bin_wide  = WIDE'(bin_q);

    // saturating accumulate on the entry just read
    rd_entry = bah_pkg::entry_t'(ram_rdata);
    sum_ext  = {rd_entry.sum[bah_pkg::SUM_W-1], rd_entry.sum}
             + {{(bah_pkg::SUM_W + 1 - 32){y_q[31]}}, y_q};
    if (sum_ext[bah_pkg::SUM_W] != sum_ext[bah_pkg::SUM_W-1]) begin
      sum_new = sum_ext[bah_pkg::SUM_W] ? bah_pkg::SUM_MIN : bah_pkg::SUM_MAX;
    end else begin
      sum_new = sum_ext[bah_pkg::SUM_W-1:0];
    end
    cnt_new = (rd_entry.count == bah_pkg::CNT_MAX) ? rd_entry.count : rd_entry.count + 1'b1;

    // sign-magnitude around the divider
    mag = rd_entry.sum[bah_pkg::SUM_W-1] ? (~rd_entry.sum + 1'b1) : rd_entry.sum;
    if (neg_q) begin
      quo_sat = (quo > bah_pkg::SUM_W'(bah_pkg::AVG_NEG_MAG)) ? bah_pkg::AVG_NEG_MAG
                                                               : quo[31:0];
      avg_val = ~quo_sat + 1'b1;
    end else begin
      quo_sat = (quo > bah_pkg::SUM_W'(bah_pkg::AVG_POS_MAX)) ? bah_pkg::AVG_POS_MAX
                                                               : quo[31:0];
      avg_val = quo_sat;
    end

    div_start = (state == S_UPD) && (op_q == bah_pkg::OP_READ) && !oor_q
             && (rd_entry.count != '0);

    // clearing pass owns the write port after reset
    ram_we    = (state == S_CLEAR) || ((state == S_UPD) && (op_q == bah_pkg::OP_ADD));
    ram_waddr = (state == S_CLEAR) ? clr_idx : bin_q;
    ram_wdata = (state == S_CLEAR) ? '0 : {sum_new, cnt_new};
  end

  assign sample.ready = (state == S_IDLE);

  // output register free or emptying this cycle
  assign out_load = (state == S_DONE) && (!out_valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == BIN_W'(NUM_BINS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (sample.valid) begin
            op_q  <= sample.opcode;
            x_q   <= sample.x_value;
            y_q   <= sample.y_value;
            rb_q  <= sample.read_bin;
            state <= (sample.opcode == bah_pkg::OP_READ) ? S_RD : S_DIFF;
          end
        end
        S_DIFF: begin
          diff_q <= diff_full[31:0];
          if (x_drop) begin
            res_status <= bah_pkg::ST_DROPPED;
            res_bin    <= '0;
            res_avg    <= '0;
            res_count  <= '0;
            state      <= S_DONE;
          end else begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod_hi <= prod[63:32];
          state   <= S_RD;
        end
        S_RD: begin
          // memory read issued at bin_sel this cycle
          bin_q <= bin_sel;
          oor_q <= (op_q == bah_pkg::OP_READ) && rd_oor;
          state <= S_UPD;
        end
        S_UPD: begin
          if (op_q == bah_pkg::OP_ADD) begin
            res_status <= bah_pkg::ST_ADDED;
            res_bin    <= bin_wide[5:0];
            res_avg    <= '0;
            res_count  <= cnt_new;
            state      <= S_DONE;
          end else begin
            res_status <= bah_pkg::ST_READ;
            res_bin    <= rb_q;
            res_avg    <= '0;
            neg_q      <= rd_entry.sum[bah_pkg::SUM_W-1];
            if (div_start) begin
              res_count <= rd_entry.count;
              state     <= S_DIV;
            end else begin
              res_count <= '0;
              state     <= S_DONE;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            res_avg <= avg_val;
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_status <= res_status;
            out_bin    <= res_bin;
            out_avg    <= res_avg;
            out_count  <= res_count;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid       = out_valid;
  assign result.status      = out_status;
  assign result.bin_index   = out_bin;
  assign result.average     = out_avg;
  assign result.entry_count = out_count;

  // one entry per bin: sum and count side by side
  bah_ram #(
    .WIDTH ($bits(bah_pkg::entry_t)),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (bin_sel),
    .rdata (ram_rdata)
  );

  // magnitude of the bin sum over its count
  bah_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag),
    .divisor  (rd_entry.count),
    .done     (div_done),
    .quotient (quo)
  );

endmodule
`default_nettype wire

// File: sv/bah_ram.sv
`default_nettype none
module bah_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: sv/bah_div.sv
`default_nettype none
module bah_div (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire bah_pkg::sum_t        dividend,
  input  wire bah_pkg::cnt_t        divisor,
  output logic                      done,
  output bah_pkg::sum_t             quotient
);

  logic                          busy;
  logic [bah_pkg::DIV_CNT_W-1:0] step;
  bah_pkg::cnt_t                 rem;
  bah_pkg::cnt_t                 dvs;
  bah_pkg::sum_t                 shreg;
  logic [bah_pkg::CNT_W:0]       trial;
  logic [bah_pkg::CNT_W:0]       diff;
  logic                          qbit;

  // restoring division, one quotient bit a cycle
  always_comb begin
    trial = {rem, shreg[bah_pkg::SUM_W-1]};
    diff  = trial - {1'b0, dvs};
    qbit  = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == bah_pkg::DIV_CNT_W'(bah_pkg::SUM_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
    if (start) begin
      step  <= '0;
      rem   <= '0;
      dvs   <= divisor;
      shreg <= dividend;
    end else if (busy) begin
      step  <= step + 1'b1;
      rem   <= qbit ? diff[bah_pkg::CNT_W-1:0] : trial[bah_pkg::CNT_W-1:0];
      shreg <= {shreg[bah_pkg::SUM_W-2:0], qbit};
    end
  end

  assign quotient = shreg;

endmodule
`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int NBINS = 64;
  localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_LO = -SUM_HI - 1;
  localparam int unsigned COUNT_TOP = 24'hFF_FFFF;

  // one request on the sample channel
  typedef struct packed {
    logic               opcode;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [5:0]         rbin;
  } sample_req_t;

  // one result on the result channel
  typedef struct packed {
    logic [1:0]         status;
    logic [5:0]         bin_index;
    logic signed [31:0] average;
    logic [23:0]        entry_count;
  } bin_report_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [bah_pkg::APB_AW-1:0] paddr;
  logic [bah_pkg::APB_DW-1:0] pwdata;
  logic [bah_pkg::APB_DW-1:0] prdata;
  logic pready;

  bah_sample_if sample_bus();
  bah_result_if result_bus();

  binned_average_histogram_top #(.NUM_BINS(NBINS)) dut (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample_bus.sink),
    .result  (result_bus.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow copy of the register file and the bin memory
  logic signed [31:0] cfg_x_min;
  logic signed [31:0] cfg_x_max;
  logic [31:0]        cfg_inv_width;
  longint             bin_sum_model[NBINS];
  int unsigned        bin_count_model[NBINS];

  // results still owed by the block, oldest first
  bin_report_t expected_results[$];

  int mismatch_count;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_off_cycles;
  int requests_sent;
  int adds_binned;
  int adds_dropped;
  int reads_sent;
  int reg_writes;

  // free-running clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("binned_average_histogram_top: mismatch");
    $finish;
  end

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    // keep the log short when everything goes wrong
    if (mismatch_count <= 40) $display("[%0t] error: %s", $realtime, what);
  endtask

  // expected result of one request; updates the shadow bins on an add
  function automatic bin_report_t histogram_predict(input sample_req_t req);
    bin_report_t rep;
    longint      diff;
    logic [63:0] prod;
    int unsigned bin;
    longint      total;
    longint      mag;
    longint      quo;
    rep = '0;
    if (req.opcode == bah_pkg::OP_ADD) begin
      // outside the closed range: dropped, state untouched
      if (req.x > cfg_x_max || req.x < cfg_x_min) begin
        rep.status = bah_pkg::ST_DROPPED;
        return rep;
      end
      // exact Q32.32 product, integer part picks the bin
      diff = longint'(req.x) - longint'(cfg_x_min);
      prod = 64'(diff) * 64'(cfg_inv_width);
      // the upper edge and oversized bins fold into the last bin
      bin = (prod[63:32] >= NBINS) ? NBINS - 1 : int'(prod[63:32]);
      total = bin_sum_model[bin] + longint'(req.y);
      if (total > SUM_HI) total = SUM_HI;
      if (total < SUM_LO) total = SUM_LO;
      bin_sum_model[bin] = total;
      if (bin_count_model[bin] < COUNT_TOP) bin_count_model[bin]++;
      rep.status      = bah_pkg::ST_ADDED;
      rep.bin_index   = bin[5:0];
      rep.entry_count = bin_count_model[bin][23:0];
    end else begin
      rep.status    = bah_pkg::ST_READ;
      rep.bin_index = req.rbin;
      // empty bin reads back as zero
      if (bin_count_model[req.rbin] == 0) return rep;
      total = bin_sum_model[req.rbin];
      mag   = (total < 0) ? -total : total;
      quo   = mag / longint'(bin_count_model[req.rbin]);
      // divide on the magnitude so the quotient truncates toward zero
      if (total < 0) begin
        if (quo > 64'sh8000_0000) quo = 64'sh8000_0000;
        rep.average = 32'(-quo);
      end else begin
        if (quo > 64'sh7FFF_FFFF) quo = 64'sh7FFF_FFFF;
        rep.average = 32'(quo);
      end
      rep.entry_count = bin_count_model[req.rbin][23:0];
    end
    return rep;
  endfunction

  function automatic sample_req_t add_req(input logic [31:0] x, input logic [31:0] y);
    sample_req_t req;
    req.opcode = bah_pkg::OP_ADD;
    req.x      = x;
    req.y      = y;
    // read_bin is a don't-care on an add, so let it wiggle
    req.rbin   = 6'($urandom);
    return req;
  endfunction

  function automatic sample_req_t read_req(input logic [5:0] rbin);
    sample_req_t req;
    req.opcode = bah_pkg::OP_READ;
    // position and value are ignored on a read
    req.x      = $urandom;
    req.y      = $urandom;
    req.rbin   = rbin;
    return req;
  endfunction

  // offer one request, hold it until accepted, then log what it should produce
  task automatic send_sample(input sample_req_t req);
    bin_report_t rep;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      sample_bus.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    sample_bus.valid    <= 1'b1;
    sample_bus.opcode   <= req.opcode;
    sample_bus.x_value  <= req.x;
    sample_bus.y_value  <= req.y;
    sample_bus.read_bin <= req.rbin;
    @(posedge clk);
    while (!sample_bus.ready) @(posedge clk);
    rep = histogram_predict(req);
    expected_results.insert(expected_results.size(), rep);
    requests_sent++;
    unique case (rep.status)
      bah_pkg::ST_ADDED:   adds_binned++;
      bah_pkg::ST_DROPPED: adds_dropped++;
      default:             reads_sent++;
    endcase
  endtask

  // stop offering and let every owed result come back
  task automatic wait_idle();
    sample_bus.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // apb write: setup phase, then access phase; pready is tied high
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    unique case (idx)
      bah_pkg::REG_X_MIN:   cfg_x_min     = value;
      bah_pkg::REG_X_MAX:   cfg_x_max     = value;
      bah_pkg::REG_INV_BIN: cfg_inv_width = value;
      default:              ;
    endcase
    reg_writes++;
  endtask

  task automatic set_range(input logic [31:0] lo, input logic [31:0] hi,
                           input logic [31:0] inv);
    write_reg(bah_pkg::REG_X_MIN, lo);
    write_reg(bah_pkg::REG_X_MAX, hi);
    write_reg(bah_pkg::REG_INV_BIN, inv);
  endtask

  // random range wide enough to spread over all bins and a bit past the top
  task automatic choose_random_range();
    longint      lo;
    longint      span;
    logic [31:0] inv;
    lo   = longint'($urandom_range(32'h7FFF_FFFF)) - 64'sd1073741824;
    span = longint'($urandom_range(32'h3FFF_FFFF, 32'h0001_0000));
    // now and then a reciprocal far too large, so most adds clamp
    if ($urandom_range(3) == 0) inv = $urandom;
    else inv = 32'(((64'd64 + $urandom_range(8)) << 32) / span);
    set_range(32'(lo), 32'(lo + span), inv);
  endtask

  function automatic sample_req_t random_sample();
    longint      span;
    logic [31:0] x;
    logic [31:0] y;
    int unsigned pick;
    if ($urandom_range(3) == 0) return read_req(6'($urandom));
    span = longint'(cfg_x_max) - longint'(cfg_x_min);
    pick = $urandom_range(19);
    // mostly inside the range, with the edges and wild positions mixed in
    if (pick < 15 && span >= 0) x = 32'(longint'(cfg_x_min) + longint'($urandom_range(32'(span))));
    else if (pick == 15) x = cfg_x_min;
    else if (pick == 16) x = cfg_x_max;
    else x = $urandom;
    pick = $urandom_range(15);
    if (pick == 0) y = 32'h7FFF_FFFF;
    else if (pick == 1) y = 32'h8000_0000;
    else if (pick < 8) y = $urandom;
    else y = 32'($urandom_range(200000)) - 32'd100000;
    return add_req(x, y);
  endfunction

  // reads of untouched bins after the clearing pass
  task automatic test_empty_bins();
    send_sample(read_req(6'd0));
    send_sample(read_req(6'd63));
  endtask

  // reset range 0 .. 64.0 with unit bins
  task automatic test_default_range_edges();
    send_sample(add_req(32'h0000_0000, 32'h7FFF_FFFF));  // lower edge, largest value
    send_sample(add_req(32'h0040_0000, 32'h8000_0000));  // upper edge folds into last bin
    send_sample(add_req(32'h0040_0001, 32'h0000_0001));  // just above the range
    send_sample(add_req(32'hFFFF_FFFF, 32'h0000_0001));  // just below the range
    send_sample(add_req(32'h8000_0000, 32'h1234_5678));  // most negative position
    send_sample(add_req(32'h7FFF_FFFF, 32'h1234_5678));  // most positive position
    send_sample(add_req(32'h000A_8000, 32'hFFFF_FFFD));  // 10.5 -> bin 10
    send_sample(add_req(32'h000A_0000, 32'hFFFF_FFFC));  // bin 10 sum now -7
    send_sample(add_req(32'h003F_FFFF, 32'h0000_0005));  // just under the top edge
    send_sample(add_req(32'h0000_FFFF, 32'h0000_0001));  // still bin 0
    send_sample(read_req(6'd0));
    send_sample(read_req(6'd10));   // negative mean truncates toward zero
    send_sample(read_req(6'd63));
    send_sample(read_req(6'd1));
  endtask

  // full signed span, largest and zero reciprocal, inverted range
  task automatic test_extreme_ranges();
    set_range(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_sample(add_req(32'h8000_0000, 32'h0000_0100));
    send_sample(add_req(32'h8000_0010, 32'hFFFF_FF00));
    send_sample(add_req(32'h7FFF_FFFF, 32'h7FFF_FFFF));
    write_reg(bah_pkg::REG_INV_BIN, 32'h0000_0000);
    send_sample(add_req($urandom, $urandom));
    // lower edge above upper edge drops everything
    set_range(32'h0000_0001, 32'h0000_0000, bah_pkg::INV_BIN_RST);
    send_sample(add_req(32'h0000_0000, 32'h0000_0007));
    send_sample(add_req(32'h0000_0001, 32'h0000_0007));
    send_sample(read_req(6'd15));
  endtask

  task automatic test_mixed_traffic(input int n);
    for (int i = 0; i < n; i++) send_sample(random_sample());
  endtask

  // receiver goes quiet while the sender keeps pushing, so the input backs up
  task automatic test_result_backpressure();
    int saved_pct;
    saved_pct = send_idle_pct;
    wait_idle();
    send_idle_pct   = 0;
    hold_off_cycles = 300;
    test_mixed_traffic(30);
    send_idle_pct = saved_pct;
  endtask

  // result ready: random stalls, or a long hold when one is requested
  initial begin : result_ready_drive
    result_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        result_bus.ready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
        result_bus.ready <= 1'b0;
        hold_off_cycles--;
      end else begin
        result_bus.ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // every accepted result against the oldest owed one
  initial begin : result_checker
    bin_report_t want;
    forever begin
      @(posedge clk);
      if (!rst && result_bus.valid && result_bus.ready) begin
        if (expected_results.size() == 0) begin
          flag_mismatch($sformatf("result with nothing owed: status %0d bin %0d",
                                  result_bus.status, result_bus.bin_index));
        end else begin
          want = expected_results.pop_front();
          if (result_bus.status !== want.status)
            flag_mismatch($sformatf("status %0d, want %0d", result_bus.status, want.status));
          if (result_bus.bin_index !== want.bin_index)
            flag_mismatch($sformatf("bin_index %0d, want %0d",
                                    result_bus.bin_index, want.bin_index));
          if (result_bus.average !== want.average)
            flag_mismatch($sformatf("bin %0d average %0d, want %0d", want.bin_index,
                                    result_bus.average, want.average));
          if (result_bus.entry_count !== want.entry_count)
            flag_mismatch($sformatf("bin %0d entry_count %0d, want %0d", want.bin_index,
                                    result_bus.entry_count, want.entry_count));
        end
      end
    end
  end

  initial begin : stimulus
    // all inputs known from time zero
    rst                 = 1'b1;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    sample_bus.valid    = 1'b0;
    sample_bus.opcode   = bah_pkg::OP_ADD;
    sample_bus.x_value  = '0;
    sample_bus.y_value  = '0;
    sample_bus.read_bin = '0;
    cfg_x_min           = bah_pkg::X_MIN_RST;
    cfg_x_max           = bah_pkg::X_MAX_RST;
    cfg_inv_width       = bah_pkg::INV_BIN_RST;
    foreach (bin_sum_model[i]) begin
      bin_sum_model[i]   = 0;
      bin_count_model[i] = 0;
    end
    mismatch_count  = 0;
    hold_off_cycles = 0;
    requests_sent   = 0;
    adds_binned     = 0;
    adds_dropped    = 0;
    reads_sent      = 0;
    reg_writes      = 0;
    // directed part runs with the first idle mix
    send_idle_pct = 17;
    recv_idle_pct = 55;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_empty_bins();
    test_default_range_edges();
    test_extreme_ranges();

    // sender mostly busy, receiver slow
    choose_random_range();
    test_mixed_traffic(170);
    choose_random_range();
    test_mixed_traffic(170);
    test_result_backpressure();

    // sender slow, receiver mostly ready
    send_idle_pct = 55;
    recv_idle_pct = 17;
    choose_random_range();
    test_mixed_traffic(170);
    choose_random_range();
    test_mixed_traffic(170);

    // no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_range(bah_pkg::X_MIN_RST, bah_pkg::X_MAX_RST, bah_pkg::INV_BIN_RST);
    test_mixed_traffic(170);
    choose_random_range();
    test_mixed_traffic(170);

    // drain, bounded, then allow for the slowest read in flight
    sample_bus.valid <= 1'b0;
    for (int w = 0; w < 20000 && expected_results.size() != 0; w++) @(posedge clk);
    if (expected_results.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    repeat (80) @(posedge clk);

    $display("covered %0d requests: %0d binned adds, %0d dropped adds, %0d bin reads",
             requests_sent, adds_binned, adds_dropped, reads_sent);
    $display("across %0d register writes, three stall mixes and one long result hold",
             reg_writes);
    if (mismatch_count == 0) begin
      $display("binned_average_histogram_top: match");
    end else begin
      $display("binned_average_histogram_top: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
sv/bah_pkg.sv
sv/bah_ifs.sv
sv/bah_ram.sv
sv/bah_div.sv
sv/binned_average_histogram_top.sv
test/tb.sv
